// ===== rtl/bfsa_pkg.sv =====
package bfsa_pkg;

	localparam int unsigned MaxJobsDefault  = 64;
	localparam int unsigned MemWordsDefault = 65536;
	localparam int unsigned SizeCeiling     = 65536;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_ADVANCE = 2'd2,
		MODE_COMPACT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP_ID   = 3'd1,
		ST_NO_FIT   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_DOWN_RD,
		S_DOWN_WR,
		S_FILT_RD,
		S_FILT_EV,
		S_REF_INIT,
		S_REF_RD,
		S_REF_EV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [23:0] remaining;
		logic [16:0] length;
		logic [16:0] base;
		logic [15:0] owner;
	} entry_t;

endpackage

// ===== rtl/bfsa_table.sv =====
module bfsa_table
	import bfsa_pkg::*;
#(
	parameter int unsigned MAX_JOBS = MaxJobsDefault,
	localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [MAX_JOBS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/best_fit_segment_allocator_top.sv =====
// Each item makes two or three passes over the address-ordered table held in
// one single-port-read memory.
// Throughput: one item at a time; the next item is taken as soon as the sequencer is idle,
// even while the previous result still waits on the output register.
// Reset: the table is empty and the memory size is the smaller of 65536 and MEM_WORDS;
// no clearing pass is needed, as only entries below the live count are ever used.
module best_fit_segment_allocator_top
	import bfsa_pkg::*;
#(
	parameter int unsigned MAX_JOBS  = MaxJobsDefault,
	parameter int unsigned MEM_WORDS = MemWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // mode
	input  logic [87:0] s_tdata,   // job_id, job_size, job_time, ticks, zero padding
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // status, placed_start, released_count, free_total,
	                               // biggest_gap, zero padding
);

	localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
	localparam int unsigned SIZE_LIMIT = (MEM_WORDS < SizeCeiling) ? MEM_WORDS : SizeCeiling;

	state_t state_q, state_d;

	logic [CNT_W-1:0] n_q, idx_q, wr_q, hitpos_q, bestpos_q, rel_q;
	logic [16:0] msize_q, prev_q, best_q, bstart_q, free_q, big_q, cursor_q;
	logic        found_q, dup_q, hit_q;
	mode_t       mode_q;
	logic [15:0] id_q;
	logic [16:0] size_q;
	logic [23:0] time_q, ticks_q;
	status_t     status_q;
	logic [15:0] placed_q;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	entry_t           mem_wdata, rdata;

	logic        tail;
	logic [16:0] base_eff, gap, end_v;
	logic [23:0] rem_new;
	logic        fit_now;
	logic [CNT_W-1:0] idx_dec;
	logic [31:0] rel_wide;

	bfsa_table #(.MAX_JOBS(MAX_JOBS)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign tail     = (idx_q == n_q);
	assign base_eff = tail ? msize_q : rdata.base;
	assign gap      = (base_eff > prev_q) ? 17'(base_eff - prev_q) : 17'd0;
	assign end_v    = 17'(rdata.base + rdata.length);
	assign rem_new  = (rdata.remaining > ticks_q) ? 24'(rdata.remaining - ticks_q) : 24'd0;
	assign fit_now  = (size_q != 17'd0) && (gap >= size_q) && (!found_q || gap < best_q);
	assign idx_dec  = CNT_W'(idx_q - 1'b1);
	assign rel_wide = 32'(rel_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (mode_t'(s_tuser))
						MODE_ALLOC, MODE_RELEASE: state_d = S_SCAN_RD;
						default:                  state_d = S_FILT_RD;
					endcase
				end
			end
			S_SCAN_RD:  state_d = S_SCAN_EV;
			S_SCAN_EV:  state_d = tail ? S_DECIDE : S_SCAN_RD;
			S_DECIDE: begin
				if (mode_q == MODE_RELEASE) begin
					state_d = hit_q ? S_DOWN_RD : S_REF_INIT;
				end else if (dup_q || !found_q || n_q == CNT_W'(MAX_JOBS)) begin
					state_d = S_REF_INIT;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: state_d = (idx_q == bestpos_q) ? S_INSERT : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_INSERT:   state_d = S_REF_INIT;
			S_DOWN_RD:  state_d = tail ? S_REF_INIT : S_DOWN_WR;
			S_DOWN_WR:  state_d = S_DOWN_RD;
			S_FILT_RD:  state_d = tail ? S_REF_INIT : S_FILT_EV;
			S_FILT_EV:  state_d = S_FILT_RD;
			S_REF_INIT: state_d = S_REF_RD;
			S_REF_RD:   state_d = S_REF_EV;
			S_REF_EV:   state_d = tail ? S_DONE : S_REF_RD;
			S_DONE:     state_d = (!m_tvalid_q || m_tready) ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Table access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = rdata;
		mem_raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_SHIFT_RD: mem_raddr = idx_dec[IDX_W-1:0];
			S_SHIFT_WR: mem_we = 1'b1;
			S_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = bestpos_q[IDX_W-1:0];
				mem_wdata = '{remaining: time_q, length: size_q, base: bstart_q, owner: id_q};
			end
			S_DOWN_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_dec[IDX_W-1:0];
			end
			S_FILT_EV: begin
				if (mode_q == MODE_ADVANCE) begin
					// Surviving jobs are packed down over the freed ones in order.
					mem_we              = (rem_new != 24'd0);
					mem_waddr           = wr_q[IDX_W-1:0];
					mem_wdata.remaining = rem_new;
				end else begin
					mem_we         = 1'b1;
					mem_wdata.base = cursor_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			msize_q    <= 17'(SIZE_LIMIT);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we && n_q == '0) begin
				if (cfg_wdata == 17'd0) begin
					msize_q <= 17'd1;
				end else if (32'(cfg_wdata) > SIZE_LIMIT) begin
					msize_q <= 17'(SIZE_LIMIT);
				end else begin
					msize_q <= cfg_wdata;
				end
			end
			case (state_q)
				S_INSERT:  n_q <= CNT_W'(n_q + 1'b1);
				// The count drops only once the entries above the released one have moved down.
				S_DOWN_RD: if (tail) n_q <= CNT_W'(n_q - 1'b1);
				S_FILT_RD: if (tail && mode_q == MODE_ADVANCE) n_q <= wr_q;
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q   <= mode_t'(s_tuser);
				id_q     <= s_tdata[15:0];
				size_q   <= s_tdata[32:16];
				time_q   <= s_tdata[56:33];
				ticks_q  <= s_tdata[80:57];
				idx_q    <= '0;
				wr_q     <= '0;
				rel_q    <= '0;
				prev_q   <= '0;
				cursor_q <= '0;
				found_q  <= 1'b0;
				dup_q    <= 1'b0;
				hit_q    <= 1'b0;
				status_q <= ST_OK;
				placed_q <= '0;
			end
			S_SCAN_EV: begin
				if (!tail) begin
					if (rdata.owner == id_q) begin
						dup_q <= 1'b1;
						if (!hit_q) begin
							hit_q    <= 1'b1;
							hitpos_q <= idx_q;
						end
					end
					prev_q <= end_v;
					idx_q  <= CNT_W'(idx_q + 1'b1);
				end
				if (fit_now) begin
					found_q   <= 1'b1;
					best_q    <= gap;
					bestpos_q <= idx_q;
					bstart_q  <= prev_q;
				end
			end
			S_DECIDE: begin
				if (mode_q == MODE_RELEASE) begin
					status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
					rel_q    <= hit_q ? CNT_W'(1) : '0;
					idx_q    <= CNT_W'(hitpos_q + 1'b1);
				end else if (dup_q) begin
					status_q <= ST_DUP_ID;
				end else if (!found_q) begin
					status_q <= ST_NO_FIT;
				end else if (n_q == CNT_W'(MAX_JOBS)) begin
					status_q <= ST_FULL;
				end
			end
			S_SHIFT_WR: idx_q <= idx_dec;
			S_INSERT:   placed_q <= bstart_q[15:0];
			S_DOWN_WR:  idx_q <= CNT_W'(idx_q + 1'b1);
			S_FILT_EV: begin
				idx_q <= CNT_W'(idx_q + 1'b1);
				if (mode_q == MODE_ADVANCE) begin
					if (rem_new == 24'd0) begin
						rel_q <= CNT_W'(rel_q + 1'b1);
					end else begin
						wr_q <= CNT_W'(wr_q + 1'b1);
					end
				end else begin
					cursor_q <= 17'(cursor_q + rdata.length);
				end
			end
			S_REF_INIT: begin
				idx_q  <= '0;
				prev_q <= '0;
				free_q <= '0;
				big_q  <= '0;
			end
			S_REF_EV: begin
				free_q <= 17'(free_q + gap);
				if (gap > big_q) begin
					big_q <= gap;
				end
				if (!tail) begin
					prev_q <= end_v;
					idx_q  <= CNT_W'(idx_q + 1'b1);
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {4'd0, big_q, free_q, rel_wide[6:0], placed_q, status_q};
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CNT_W'(MAX_JOBS))
		else $error("live job count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INSERT |=> n_q == CNT_W'($past(n_q) + 1'b1))
		else $error("insert did not grow the table by one");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REF_EV && tail |=> free_q <= msize_q && big_q <= free_q)
		else $error("free space summary inconsistent");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready && state_q == S_DONE |=> state_q == S_DONE)
		else $error("result overwritten while output stalled");

endmodule
